[hw/rtl/dwt_lr_pkg.sv]
// Shared types and constants for the wavelet coefficient layout reorder block.
package dwt_lr_pkg;

  localparam int POS_W          = 10;
  localparam int WORD_W         = 64;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 4;
  localparam int LOG2_LEN_RESET = 10;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic {
    DIR_ITC = 1'b0,
    DIR_CTI = 1'b1
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION   = 1'b0,
    CFG_LOG2_LENGTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] word;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_word;
    logic              bad_index;
  } out_item_t;

endpackage

[hw/rtl/dwt_lr_if.sv]
// Valid/ready stream channel carrying one payload item per transaction.
interface dwt_lr_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/dwt_layout_reorder_core.sv]
// Each input passes the s1 and s2 stage registers and then the result register.
// Throughput: one item per cycle; each in-range item makes one access to the
// coefficient RAM, and a stalled result holds the pipeline behind it.
// Reset clears the pipeline valid flags, direction (to interleaved-to-coalesced)
// and log2_length (to 10, at most MAX_LOG2_LEN). The coefficient RAM is not
// cleared; entries read before being stored return undefined data.
module dwt_layout_reorder_core
  import dwt_lr_pkg::*;
#(
  parameter int MAX_LOG2_LEN = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  dwt_lr_if.sink                items,
  dwt_lr_if.source              results,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW    = MAX_LOG2_LEN;
  localparam int DEPTH = 1 << MAX_LOG2_LEN;
  localparam int KW    = $clog2(MAX_LOG2_LEN + 1);
  localparam int EW    = ((MAX_LOG2_LEN > POS_W) ? MAX_LOG2_LEN : POS_W) + 1;
  localparam int K_RST = (MAX_LOG2_LEN < LOG2_LEN_RESET) ? MAX_LOG2_LEN : LOG2_LEN_RESET;

  function automatic logic [KW-1:0] msb_index(input logic [EW-1:0] v);
    logic [KW-1:0] r;
    r = '0;
    for (int j = 0; j < EW; j++) begin
      if (v[j]) r = KW'(j);
    end
    return r;
  endfunction

  function automatic logic [KW-1:0] lsb_index(input logic [EW-1:0] v);
    logic [KW-1:0] r;
    r = '0;
    for (int j = EW - 1; j >= 0; j--) begin
      if (v[j]) r = KW'(j);
    end
    return r;
  endfunction

  // configuration
  dir_t          dir;
  logic [KW-1:0] k;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir <= DIR_ITC;
      k   <= KW'(K_RST);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DIRECTION: begin
          dir <= dir_t'(cfg_data[0]);
        end
        CFG_LOG2_LENGTH: begin
          // clamp to the supported range
          if (cfg_data == '0) begin
            k <= KW'(1);
          end else if (32'(cfg_data) > MAX_LOG2_LEN) begin
            k <= KW'(MAX_LOG2_LEN);
          end else begin
            k <= KW'(cfg_data);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // pipeline control
  logic              s1_v;
  op_t               s1_op;
  logic [POS_W-1:0]  s1_pos;
  logic [WORD_W-1:0] s1_word;
  logic              s2_v;
  op_t               s2_op;
  logic              s2_bad;
  logic              s1_adv;
  logic              s2_adv;
  logic              in_take;

  assign s2_adv      = !results.valid || results.ready;
  assign s1_adv      = !s2_v || s2_adv;
  assign items.ready = !s1_v || s1_adv;
  assign in_take     = items.valid && items.ready;

  // source index calculation
  logic [EW-1:0] o;
  logic [EW-1:0] len_e;
  logic [EW-1:0] mask;
  logic [EW-1:0] c;
  logic [KW-1:0] p;
  logic [KW-1:0] lev;
  logic [EW-1:0] i_part;
  logic [EW-1:0] src_itc;
  logic [KW-1:0] t;
  logic [EW-1:0] src_cti;
  logic [EW-1:0] src;
  logic          s1_bad;

  always_comb begin
    o      = EW'(s1_pos);
    len_e  = EW'(1) << k;
    mask   = len_e - EW'(1);
    s1_bad = o >= len_e;

    // interleaved to coalesced: level from the leading ones of the index
    c       = ~o & mask;
    p       = msb_index(c);
    lev     = k - KW'(1) - p;
    i_part  = o & ((EW'(1) << p) - EW'(1));
    src_itc = (c == '0) ? '0 : ((((i_part << 1) | EW'(1))) << lev);

    // coalesced to interleaved: level from the trailing zeros of the index
    t       = lsb_index(o);
    src_cti = (o == '0) ? mask
            : (len_e - (len_e >> t) + (o >> ({1'b0, t} + (KW + 1)'(1))));

    src = (dir == DIR_CTI) ? src_cti : src_itc;
  end

  // coefficient buffer
  logic              ram_en;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [WORD_W-1:0] ram_rdata;

  assign ram_en   = s1_v && s1_adv && !s1_bad;
  assign ram_we   = (s1_op == OP_STORE);
  assign ram_addr = (s1_op == OP_STORE) ? o[AW-1:0] : src[AW-1:0];

  dwt_lr_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_buf (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(s1_word),
    .rdata(ram_rdata)
  );

  // stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v          <= 1'b0;
      s2_v          <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (items.ready) begin
        s1_v <= items.valid;
      end
      if (s1_adv) begin
        s2_v <= s1_v;
      end
      if (s2_adv) begin
        results.valid <= s2_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op   <= items.data.op;
      s1_pos  <= items.data.position;
      s1_word <= items.data.word;
    end
    if (s1_v && s1_adv) begin
      s2_op  <= s1_op;
      s2_bad <= s1_bad;
    end
    if (s2_v && s2_adv) begin
      results.data.read_word <= (s2_op == OP_READ && !s2_bad) ? ram_rdata : '0;
      results.data.bad_index <= s2_bad;
    end
  end

  // hold read data while the result stage is stalled
  a_rdata_hold: assert property (@(posedge clk) disable iff (rst)
    s2_v && !s2_adv |=> $stable(ram_rdata))
    else $error("RAM read data changed under a stalled result");

  a_src_range: assert property (@(posedge clk) disable iff (rst)
    s1_v && !s1_bad |-> src < len_e)
    else $error("source index beyond vector length");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.data.bad_index |-> results.data.read_word == '0)
    else $error("bad index transaction returned nonzero data");

  a_rst_idle: assert property (@(posedge clk)
    $past(rst) |-> !results.valid && !s1_v && !s2_v)
    else $error("pipeline not empty after reset");

endmodule

[hw/rtl/dwt_lr_ram.sv]
// Generic single-port RAM with registered read data.
module dwt_lr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
